>>> sv/msseq_pkg.sv
// ----------------------------------------------------------------------------
// msseq_pkg: shared types and constants of the microstep sequencer
// Item kinds, configuration register indexes, PWM output modes and the
// drive word that the output stage holds.
// ----------------------------------------------------------------------------
`default_nettype none

package msseq_pkg;

  localparam int unsigned DefTableSteps = 72;
  localparam logic [11:0] FullScaleReset = 12'd400;

  // Phase increment per tick is floor(speed * 360 * 32768 / 60 / 10000).
  // The ratio reduces to 3 * 2^12 / 625; the division by 625 is done as a
  // multiplication by ceil(2^35 / 625), exact for every 11-bit speed.
  localparam longint unsigned IncRecipL =
    64'd3 * (((64'd1 << 35) + 64'd624) / 64'd625);
  localparam int unsigned IncRecipW = 28;
  localparam int unsigned IncShift  = 23;
  localparam logic [IncRecipW-1:0] IncRecip = IncRecipL[IncRecipW-1:0];

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_CLEAR = 3'd2,
    KIND_LOAD  = 3'd3,
    KIND_FORCE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CFG_SPEED      = 2'd0,
    CFG_FULL_SCALE = 2'd1,
    CFG_ENABLE     = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    MODE_LOW          = 2'd0,
    MODE_TOGGLE_RESET = 2'd1,
    MODE_TOGGLE_SET   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [11:0] a_cmp;
    mode_e       a_mode;
    logic        a_neg;
    logic [11:0] b_cmp;
    mode_e       b_mode;
    logic        b_pos;
  } drive_t;

endpackage

`default_nettype wire

>>> sv/msseq_ctrl.sv
// ----------------------------------------------------------------------------
// msseq_ctrl: step control state
// Holds the phase accumulator, the pending step count and the table
// position, and works out their next values for the item in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module msseq_ctrl #(
  parameter int unsigned TableSteps = msseq_pkg::DefTableSteps,
  localparam int unsigned PosW = $clog2(TableSteps)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [10:0]           speed_i,
  input  wire logic                  adv_i,
  input  wire msseq_pkg::kind_e      kind_i,
  input  wire logic signed [31:0]    step_count_i,
  input  wire logic                  direction_i,
  output logic                       stepped_o,
  output logic [PosW-1:0]            pos_o,
  output logic signed [31:0]         pending_o
);
  import msseq_pkg::*;

  localparam logic [PosW-1:0] PosLast = PosW'(TableSteps - 1);
  localparam int unsigned ProdW = 11 + IncRecipW;

  logic [15:0]        inc_q, inc_d;
  logic [14:0]        acc_q, acc_d;
  logic signed [31:0] pending_q, pending_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [ProdW-1:0]   inc_prod;
  logic [15:0]        acc_sum;
  logic               wrap;
  logic [PosW-1:0]    pos_fwd, pos_bwd;
  logic signed [32:0] add_sum;
  logic               stepped;

  // The speed should only change while the block is idle (the block does not
  // enforce this); the increment is simply recomputed into a register every cycle.
  assign inc_prod = ProdW'(speed_i) * ProdW'(IncRecip);
  assign inc_d    = inc_prod[IncShift +: 16];

  assign acc_sum = {1'b0, acc_q} + inc_q;
  assign wrap    = acc_sum[15];
  assign pos_fwd = (pos_q == PosLast) ? '0 : pos_q + PosW'(1);
  assign pos_bwd = (pos_q == '0) ? PosLast : pos_q - PosW'(1);
  assign add_sum = {pending_q[31], pending_q} + {step_count_i[31], step_count_i};

  always_comb begin
    acc_d     = acc_q;
    pending_d = pending_q;
    pos_d     = pos_q;
    stepped   = 1'b0;
    unique case (kind_i)
      KIND_TICK: begin
        acc_d = acc_sum[14:0];
        if (wrap && pending_q > 0) begin
          pending_d = pending_q - 32'sd1;
          pos_d     = pos_fwd;
          stepped   = 1'b1;
        end else if (wrap && pending_q < 0) begin
          pending_d = pending_q + 32'sd1;
          pos_d     = pos_bwd;
          stepped   = 1'b1;
        end
      end
      KIND_ADD: begin
        // Saturate at the 32-bit signed limits when the sign is lost.
        if (add_sum[32] != add_sum[31]) begin
          pending_d = add_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          pending_d = add_sum[31:0];
        end
      end
      KIND_CLEAR: begin
        pending_d = '0;
      end
      KIND_LOAD: begin
        acc_d = acc_q;
      end
      KIND_FORCE: begin
        pos_d   = direction_i ? pos_bwd : pos_fwd;
        stepped = 1'b1;
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q     <= '0;
      acc_q     <= '0;
      pending_q <= '0;
      pos_q     <= PosLast;
    end else begin
      inc_q <= inc_d;
      if (adv_i) begin
        acc_q     <= acc_d;
        pending_q <= pending_d;
        pos_q     <= pos_d;
      end
    end
  end

  assign stepped_o = stepped;
  assign pos_o     = pos_d;
  assign pending_o = pending_d;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("table position beyond the last step");

  a_no_step_without_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_i == KIND_TICK && !wrap) |-> !stepped)
    else $error("tick stepped without an accumulator wrap");

  a_tick_step_moves_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && kind_i == KIND_TICK && stepped) |=>
      (pending_q == $past(pending_q) - 32'sd1 || pending_q == $past(pending_q) + 32'sd1))
    else $error("tick step did not move the pending count by one");

endmodule

`default_nettype wire

>>> sv/msseq_vtable.sv
// ----------------------------------------------------------------------------
// msseq_vtable: microstep voltage table
// Two memories with a write port and a read port each, one for phase A
// words and one for phase B words, written by table loads and read at the new position on each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module msseq_vtable #(
  parameter int unsigned TableSteps = msseq_pkg::DefTableSteps,
  localparam int unsigned PosW = $clog2(TableSteps),
  localparam int unsigned IdxW = $clog2(2 * TableSteps)
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic                  wr_i,
  input  wire logic [IdxW-1:0]       idx_i,
  input  wire logic signed [15:0]    value_i,
  input  wire logic [PosW-1:0]       rd_pos_i,
  output logic signed [15:0]         rd_a_o,
  output logic signed [15:0]         rd_b_o
);

  localparam int unsigned WordCount = 2 * TableSteps;

  logic signed [15:0] mem_a [TableSteps];
  logic signed [15:0] mem_b [TableSteps];
  logic               wr_ok;
  logic [PosW-1:0]    wr_row;

  // Words past the end of the table are dropped.
  assign wr_ok  = en_i && wr_i && ({1'b0, idx_i} < (IdxW + 1)'(WordCount));
  assign wr_row = idx_i[IdxW-1:1];

  always_ff @(posedge clk_i) begin
    if (wr_ok && !idx_i[0]) begin
      mem_a[wr_row] <= value_i;
    end
    if (wr_ok && idx_i[0]) begin
      mem_b[wr_row] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_a_o <= mem_a[rd_pos_i];
      rd_b_o <= mem_b[rd_pos_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/msseq_drive.sv
// ----------------------------------------------------------------------------
// msseq_drive: bridge drive mapping
// Scales the A and B table voltages to the PWM full scale and turns them
// into compare values, output modes and static pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

module msseq_drive (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  mul_en_i,
  input  wire logic                  map_en_i,
  input  wire logic [11:0]           full_scale_i,
  input  wire logic signed [15:0]    volt_a_i,
  input  wire logic signed [15:0]    volt_b_i,
  output msseq_pkg::drive_t          drive_o
);
  import msseq_pkg::*;

  logic signed [28:0] mul_a, mul_b;
  logic signed [27:0] prod_a_q, prod_b_q;
  logic signed [12:0] c_a, c_b, neg_a, neg_b;
  logic [12:0]        sum_a, sum_b;
  drive_t             drive_q, drive_d;

  assign mul_a = volt_a_i * $signed({1'b0, full_scale_i});
  assign mul_b = volt_b_i * $signed({1'b0, full_scale_i});

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_a_q <= mul_a[27:0];
      prod_b_q <= mul_b[27:0];
    end
  end

  // Arithmetic shift gives the floor of the division by 2^15.
  assign c_a   = prod_a_q[27:15];
  assign c_b   = prod_b_q[27:15];
  assign neg_a = -c_a;
  assign neg_b = -c_b;
  assign sum_a = {1'b0, full_scale_i} + c_a;
  assign sum_b = {1'b0, full_scale_i} + neg_b;

  always_comb begin
    drive_d = drive_q;
    if (!c_a[12]) begin
      drive_d.a_cmp  = sum_a[12:1];
      drive_d.a_mode = MODE_TOGGLE_RESET;
      drive_d.a_neg  = 1'b0;
    end else begin
      drive_d.a_cmp  = neg_a[11:0];
      drive_d.a_mode = MODE_TOGGLE_SET;
      drive_d.a_neg  = 1'b1;
    end
    if (!c_b[12]) begin
      drive_d.b_cmp  = c_b[11:0];
      drive_d.b_mode = MODE_TOGGLE_SET;
      drive_d.b_pos  = 1'b1;
    end else begin
      drive_d.b_cmp  = sum_b[12:1];
      drive_d.b_mode = MODE_TOGGLE_RESET;
      drive_d.b_pos  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= '{a_cmp: '0, a_mode: MODE_LOW, a_neg: 1'b0,
                   b_cmp: '0, b_mode: MODE_LOW, b_pos: 1'b0};
    end else if (map_en_i) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

`default_nettype wire

>>> sv/microstep_motor_sequencer_core.sv
// ----------------------------------------------------------------------------
// microstep_motor_sequencer_core: two-phase stepper microstep sequencer
// Takes ticks, step commands and table loads, and returns one drive result
// per input beat.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat, in order. The block takes
// one beat per cycle when the input is ready; a result passes from the input
// register through the table read, scaling multiply and output register
// stages, and the four stages absorb stalls on the output side, so input
// stays ready while any stage is free. The step state (accumulator, pending
// count, position) closes its loop in the input stage. A speed write takes
// effect for beats taken from the cycle after the write. A full-scale write
// changes the drive only on the next step.
`default_nettype none

module microstep_motor_sequencer_core #(
  parameter int unsigned TableSteps = msseq_pkg::DefTableSteps,
  localparam int unsigned PosW = $clog2(TableSteps),
  localparam int unsigned IdxW = $clog2(2 * TableSteps)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [11:0]           cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            kind_i,
  input  wire logic signed [31:0]    step_count_i,
  input  wire logic [IdxW-1:0]       table_index_i,
  input  wire logic signed [15:0]    table_value_i,
  input  wire logic                  direction_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       stepped_o,
  output logic [PosW-1:0]            position_o,
  output logic [11:0]                a_compare_o,
  output logic [1:0]                 a_out_mode_o,
  output logic                       a_neg_level_o,
  output logic [11:0]                b_compare_o,
  output logic [1:0]                 b_out_mode_o,
  output logic                       b_pos_level_o,
  output logic signed [31:0]         pending_steps_o,
  output logic                       enable_level_o
);
  import msseq_pkg::*;

  logic [10:0] speed_q;
  logic [11:0] full_scale_q;
  logic        enable_q;

  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;
  logic adv1, adv2, adv3;

  kind_e              kind_q;
  logic signed [31:0] step_count_q;
  logic [IdxW-1:0]    index_q;
  logic signed [15:0] value_q;
  logic               direction_q;

  logic               stepped_c;
  logic [PosW-1:0]    pos_c;
  logic signed [31:0] pending_c;

  logic               st2_q, st3_q, sto_q;
  logic [PosW-1:0]    pos2_q, pos3_q, poso_q;
  logic signed [31:0] pend2_q, pend3_q, pendo_q;

  logic signed [15:0] volt_a, volt_b;
  drive_t             drive;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q      <= '0;
      full_scale_q <= FullScaleReset;
      enable_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_SPEED:      speed_q      <= cfg_data_i[10:0];
        CFG_FULL_SCALE: full_scale_q <= cfg_data_i;
        CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        default:        enable_q     <= enable_q;
      endcase
    end
  end

  // A stage takes a new beat when it is empty or its beat moves on.
  assign rdyo = !vo_q || out_ready_i;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign adv3 = v3_q && rdyo;
  assign adv2 = v2_q && rdy3;
  assign adv1 = v1_q && rdy2;

  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      kind_q       <= kind_e'(kind_i);
      step_count_q <= step_count_i;
      index_q      <= table_index_i;
      value_q      <= table_value_i;
      direction_q  <= direction_i;
    end
    if (adv1) begin
      st2_q   <= stepped_c;
      pos2_q  <= pos_c;
      pend2_q <= pending_c;
    end
    if (adv2) begin
      st3_q   <= st2_q;
      pos3_q  <= pos2_q;
      pend3_q <= pend2_q;
    end
    if (adv3) begin
      sto_q   <= st3_q;
      poso_q  <= pos3_q;
      pendo_q <= pend3_q;
    end
  end

  msseq_ctrl #(
    .TableSteps (TableSteps)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .speed_i      (speed_q),
    .adv_i        (adv1),
    .kind_i       (kind_q),
    .step_count_i (step_count_q),
    .direction_i  (direction_q),
    .stepped_o    (stepped_c),
    .pos_o        (pos_c),
    .pending_o    (pending_c)
  );

  msseq_vtable #(
    .TableSteps (TableSteps)
  ) u_vtable (
    .clk_i    (clk_i),
    .en_i     (adv1),
    .wr_i     (kind_q == KIND_LOAD),
    .idx_i    (index_q),
    .value_i  (value_q),
    .rd_pos_i (pos_c),
    .rd_a_o   (volt_a),
    .rd_b_o   (volt_b)
  );

  msseq_drive u_drive (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mul_en_i     (adv2),
    .map_en_i     (adv3 && st3_q),
    .full_scale_i (full_scale_q),
    .volt_a_i     (volt_a),
    .volt_b_i     (volt_b),
    .drive_o      (drive)
  );

  assign out_valid_o     = vo_q;
  assign stepped_o       = sto_q;
  assign position_o      = poso_q;
  assign a_compare_o     = drive.a_cmp;
  assign a_out_mode_o    = drive.a_mode;
  assign a_neg_level_o   = drive.a_neg;
  assign b_compare_o     = drive.b_cmp;
  assign b_out_mode_o    = drive.b_mode;
  assign b_pos_level_o   = drive.b_pos;
  assign pending_steps_o = pendo_q;
  assign enable_level_o  = enable_q;

  a_ready_when_stage_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q || !v2_q || !v3_q || !vo_q || out_ready_i) |-> in_ready_o)
    else $error("input stalled while a pipeline stage was free");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && vo_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while every stage was full");

  a_drive_holds_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv3 && st3_q) |=> $stable(drive))
    else $error("drive word changed without a step");

endmodule

`default_nettype wire
